[rtl/core/pgc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgc_pkg
// Constants, types and elaboration-time tables for the gamma correction core.
// ----------------------------------------------------------------------------
package pgc_pkg;

    // fraction bits of the log2 / exp2 datapath
    localparam int LOG_FRAC_BITS = 16;
    // log difference and quotient width: 3 integer bits plus the fraction
    localparam int DW = LOG_FRAC_BITS + 3;
    // numerator width: log difference times 256
    localparam int NW = DW + 8;
    // pipeline depth: input, range check, DW divide steps, exp setup,
    // LOG_FRAC_BITS multiply steps, output scaling
    localparam int LAT = DW + LOG_FRAC_BITS + 4;

    typedef logic [DW-1:0] t_dlog;
    typedef logic [31:0]   t_q32;
    typedef t_dlog t_dtab [256];
    typedef t_q32  t_ctab [LOG_FRAC_BITS+1];

    // special handling carried with each channel
    typedef enum logic [1:0] {
        SP_NONE,
        SP_ZERO,
        SP_FULL
    } t_spec;

    // integer square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_w;
        logic [63:0] rem;
        res   = '0;
        rem   = v;
        bit_w = 64'd1 << 62;
        while (bit_w > rem)
            bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (rem >= res + bit_w) begin
                rem = rem - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    // log2 of 1..255 with LOG_FRAC_BITS fraction bits, by repeated squaring
    function automatic logic [63:0] log2_fix(input logic [63:0] v);
        int          k;
        logic [63:0] z;
        logic [63:0] r;
        k = 0;
        while (k < 7 && (v >> (k + 1)) != 0)
            k++;
        z = v << (30 - k);
        r = 64'(k) << LOG_FRAC_BITS;
        for (int i = 1; i <= LOG_FRAC_BITS; i++) begin
            z = (z * z) >> 30;
            if (z >= (64'd2 << 30)) begin
                z = z >> 1;
                r = r | (64'd1 << (LOG_FRAC_BITS - i));
            end
        end
        return r;
    endfunction

    // log2(255) - log2(x) for every byte value
    function automatic t_dtab build_dtab();
        t_dtab       tab;
        logic [63:0] top;
        logic [63:0] lx;
        top = log2_fix(64'd255);
        for (int v = 0; v < 256; v++) begin
            lx     = log2_fix((v == 0) ? 64'd1 : 64'(v));
            tab[v] = (top > lx) ? DW'(top - lx) : '0;
        end
        return tab;
    endfunction

    // 2^(-2^-k) in Q32
    function automatic t_ctab build_ctab();
        t_ctab tab;
        tab[0] = '0;
        tab[1] = 32'(isqrt64(64'd1 << 63));
        for (int k = 2; k <= LOG_FRAC_BITS; k++)
            tab[k] = 32'(isqrt64({tab[k-1], 32'd0}));
        return tab;
    endfunction

    localparam t_dtab D_TAB = build_dtab();
    localparam t_ctab C_TAB = build_ctab();

endpackage

[rtl/core/pgc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgc_in_if
// Pixel input channel: valid/ready handshake with four byte fields.
// ----------------------------------------------------------------------------
interface pgc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan_a_in;
    logic [7:0] chan_b_in;
    logic [7:0] chan_c_in;
    logic [7:0] alpha_in;

    modport source (output valid, output chan_a_in, output chan_b_in,
                    output chan_c_in, output alpha_in, input ready);
    modport sink   (input valid, input chan_a_in, input chan_b_in,
                    input chan_c_in, input alpha_in, output ready);
endinterface

[rtl/core/pgc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgc_out_if
// Pixel output channel: valid/ready handshake with four byte fields.
// ----------------------------------------------------------------------------
interface pgc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan_a_out;
    logic [7:0] chan_b_out;
    logic [7:0] chan_c_out;
    logic [7:0] alpha_out;

    modport source (output valid, output chan_a_out, output chan_b_out,
                    output chan_c_out, output alpha_out, input ready);
    modport sink   (input valid, input chan_a_out, input chan_b_out,
                    input chan_c_out, input alpha_out, output ready);
endinterface

[rtl/core/pgc_chan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgc_chan
// One color channel datapath: log table, restoring divide by gamma, exp2 by
// a chain of Q32 multiplies, output scaling.
// ----------------------------------------------------------------------------
module pgc_chan
    import pgc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_gamma,
    input  logic [7:0]  i_x,
    output logic [7:0]  o_y
);

    // input stage: log difference scaled by 256
    logic [NW-1:0] r_num;
    t_spec         r_sp0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= {D_TAB[i_x], 8'd0};
            if (i_x == 8'd0)
                r_sp0 <= SP_ZERO;
            else if (i_x == 8'd255)
                r_sp0 <= SP_FULL;
            else
                r_sp0 <= SP_NONE;
        end
    end

    // divide stages; index 0 holds the range check result
    logic [15:0]   r_rem  [DW+1];
    logic [DW-1:0] r_quo  [DW+1];
    logic [DW-1:0] r_low  [DW+1];
    t_spec         r_spd  [DW+1];

    logic [DW+15:0] w_lim;
    assign w_lim = {i_gamma, DW'(0)};

    // quotient of eight or more whole octaves drives the output to zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= 16'(r_num[NW-1:DW]);
            r_quo[0] <= '0;
            r_low[0] <= r_num[DW-1:0];
            if (r_sp0 == SP_NONE && (DW+16)'(r_num) >= w_lim)
                r_spd[0] <= SP_ZERO;
            else
                r_spd[0] <= r_sp0;
        end
    end

    for (genvar j = 1; j <= DW; j++) begin : g_div
        logic [16:0] w_try;
        logic        w_ge;
        assign w_try = {r_rem[j-1], r_low[j-1][DW-j]};
        assign w_ge  = (w_try >= {1'b0, i_gamma});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= w_ge ? 16'(w_try - {1'b0, i_gamma}) : w_try[15:0];
                r_quo[j] <= {r_quo[j-1][DW-2:0], w_ge};
                r_low[j] <= r_low[j-1];
                r_spd[j] <= r_spd[j-1];
            end
        end
    end

    // exp2 stages; r_one marks a mantissa of exactly one
    logic [31:0]            r_m   [LOG_FRAC_BITS+1];
    logic                   r_one [LOG_FRAC_BITS+1];
    logic [LOG_FRAC_BITS-1:0] r_f [LOG_FRAC_BITS+1];
    logic [2:0]             r_n   [LOG_FRAC_BITS+1];
    t_spec                  r_spe [LOG_FRAC_BITS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]   <= '0;
            r_one[0] <= 1'b1;
            r_f[0]   <= r_quo[DW][LOG_FRAC_BITS-1:0];
            r_n[0]   <= r_quo[DW][DW-1:LOG_FRAC_BITS];
            r_spe[0] <= r_spd[DW];
        end
    end

    for (genvar k = 1; k <= LOG_FRAC_BITS; k++) begin : g_exp
        logic [63:0] w_prod;
        assign w_prod = 64'(r_m[k-1]) * 64'(C_TAB[k]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_f[k-1][LOG_FRAC_BITS-k]) begin
                    r_m[k]   <= r_one[k-1] ? C_TAB[k] : w_prod[63:32];
                    r_one[k] <= 1'b0;
                end else begin
                    r_m[k]   <= r_m[k-1];
                    r_one[k] <= r_one[k-1];
                end
                r_f[k]   <= r_f[k-1];
                r_n[k]   <= r_n[k-1];
                r_spe[k] <= r_spe[k-1];
            end
        end
    end

    // output scaling: 255 * m / 2^(32+n), limited to 255
    logic [32:0] w_mv;
    logic [40:0] w_p;
    logic [8:0]  w_sh;
    logic [7:0]  r_y;

    assign w_mv = {r_one[LOG_FRAC_BITS], r_m[LOG_FRAC_BITS]};
    assign w_p  = 41'(w_mv) * 41'd255;
    assign w_sh = 9'(w_p >> (6'd32 + 6'(r_n[LOG_FRAC_BITS])));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_spe[LOG_FRAC_BITS])
                SP_ZERO: r_y <= 8'd0;
                SP_FULL: r_y <= 8'd255;
                default: r_y <= w_sh[8] ? 8'd255 : w_sh[7:0];
            endcase
        end
    end

    assign o_y = r_y;

endmodule

[rtl/core/pixel_gamma_correction.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_gamma_correction
// Gamma correction of one four-byte pixel per beat.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix carries one pixel per beat: three color bytes and a fourth byte
//   that is copied through. o_pix returns the corrected pixel in order.
//   i_cfg_we / i_cfg_data write gamma (unsigned Q8.8, zero acts as 1/256);
//   write it only while no pixel is in flight.
//   Stages: one input stage, a range check, one divide step per quotient
//   bit, an exp2 setup stage, one Q32 multiply per fraction bit of the
//   exponent, then output scaling.
//   Throughput is one pixel per cycle while the pipeline is not stalled;
//   each divide step and each multiply holds its own stage register.
//   Reset clears all valid bits and loads gamma = 3/256.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and i_pix.ready drops; nothing is dropped or repeated. While the
//   output register is empty, the pipeline keeps advancing and beats keep
//   entering.
// ----------------------------------------------------------------------------
module pixel_gamma_correction
    import pgc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    pgc_in_if.sink      i_pix,
    pgc_out_if.source   o_pix
);

    // gamma register
    logic [15:0] r_gamma;
    logic [15:0] w_gamma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= 16'd3;
        end else if (i_cfg_we) begin
            r_gamma <= i_cfg_data;
        end
    end

    assign w_gamma = (r_gamma == 16'd0) ? 16'd1 : r_gamma;

    // pipeline advance: last stage empty or being taken
    logic r_vld [LAT];
    logic w_en;

    assign w_en        = !r_vld[LAT-1] || o_pix.ready;
    assign i_pix.ready = w_en;

    // valid bits and pass-through byte
    logic [7:0] r_alpha [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_alpha[0] <= i_pix.alpha_in;
        end
    end

    for (genvar s = 1; s < LAT; s++) begin : g_line
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_en) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_alpha[s] <= r_alpha[s-1];
            end
        end
    end

    // color channel datapaths
    pgc_chan u_chan_a (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_gamma (w_gamma),
        .i_x     (i_pix.chan_a_in),
        .o_y     (o_pix.chan_a_out)
    );

    pgc_chan u_chan_b (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_gamma (w_gamma),
        .i_x     (i_pix.chan_b_in),
        .o_y     (o_pix.chan_b_out)
    );

    pgc_chan u_chan_c (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_gamma (w_gamma),
        .i_x     (i_pix.chan_c_in),
        .o_y     (o_pix.chan_c_out)
    );

    assign o_pix.valid     = r_vld[LAT-1];
    assign o_pix.alpha_out = r_alpha[LAT-1];

endmodule
